// File: rtl/pate_pkg.sv
// Package for the packed array table engine: sizes, codes and the types
// shared by the top level and the storage cell. No dependencies.

package pate_pkg;

  localparam int DEPTH   = 128;
  localparam int WORD_W  = 32;
  localparam int IDX_IN_W = 8;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  // Position, index and count are compared at this common width.
  localparam int CMP_W   = (CNT_W > IDX_IN_W) ? CNT_W : IDX_IN_W;
  localparam int SWP_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2,
    OP_WRITE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EXEC  = 4'b0010,
    S_SWEEP = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  // Command broadcast to every cell.
  typedef struct packed {
    logic                     app;
    logic                     del;
    logic                     wr;
    logic [CMP_W-1:0]         idx;
    logic [CMP_W-1:0]         cnt;
    logic signed [WORD_W-1:0] value;
  } cell_cmd_t;

  // Running maximum and minimum handed down the chain.
  typedef struct packed {
    logic                     any;
    logic signed [WORD_W-1:0] hi;
    logic signed [WORD_W-1:0] lo;
  } minmax_t;

endpackage

// File: rtl/pate_cell.sv
// One storage cell of the table: holds one entry, shifts on delete and
// passes a running max/min and a read word on to its neighbor. Uses pate_pkg.

module pate_cell
  import pate_pkg::*;
(
  input  logic                     clk,
  input  logic [CMP_W-1:0]         pos,
  input  cell_cmd_t                cmd,
  input  logic signed [WORD_W-1:0] next_entry,
  output logic signed [WORD_W-1:0] entry,
  input  minmax_t                  prev_mm,
  output minmax_t                  mm,
  input  logic signed [WORD_W-1:0] prev_rd,
  output logic signed [WORD_W-1:0] rd
);

  logic in_use;
  logic load_own;
  logic load_next;

  assign in_use    = pos < cmd.cnt;
  assign load_own  = (cmd.app && pos == cmd.cnt) || (cmd.wr && pos == cmd.idx);
  assign load_next = cmd.del && pos >= cmd.idx && (pos + CMP_W'(1)) < cmd.cnt;

  always_ff @(posedge clk) begin
    if (load_own) begin
      entry <= cmd.value;
    end else if (load_next) begin
      entry <= next_entry;
    end
  end

  // The reduction runs every cycle; it settles one cell per cycle after
  // the entries stop changing.
  always_ff @(posedge clk) begin
    if (!in_use) begin
      mm <= prev_mm;
    end else if (!prev_mm.any) begin
      mm <= '{any: 1'b1, hi: entry, lo: entry};
    end else begin
      mm.any <= 1'b1;
      mm.hi  <= (entry > prev_mm.hi) ? entry : prev_mm.hi;
      mm.lo  <= (entry < prev_mm.lo) ? entry : prev_mm.lo;
    end
    rd <= (pos == cmd.idx) ? entry : prev_rd;
  end

endmodule

// File: rtl/packed_array_table_engine.sv
// Top level of the packed array table engine: sequencer, count register and
// the chain of pate_cell storage cells. Uses pate_pkg.
//
//   channel   signals                                      handshake
//   command   opcode, index, value                         start && !busy
//   result    read_word, status, count, max_word, min_word done strobe, 1 cycle
//
// Each beat passes from acceptance to its result strobe through S_EXEC,
// which applies the operation to the cells, S_SWEEP, while the max/min
// and read word ripple down the cell chain, and S_EMIT, which registers
// the result. busy is low again in the strobe cycle, so the next command
// may be accepted there. Synchronous reset empties the table; entries
// themselves are not cleared. The receiver cannot stall the result.

module packed_array_table_engine
  import pate_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               opcode,
  input  logic [IDX_IN_W-1:0]      index,
  input  logic signed [WORD_W-1:0] value,
  output logic                     done,
  output logic signed [WORD_W-1:0] read_word,
  output logic [1:0]               status,
  output logic [7:0]               count,
  output logic signed [WORD_W-1:0] max_word,
  output logic signed [WORD_W-1:0] min_word
);

  state_t                   state, state_next;
  op_t                      op;
  logic [CMP_W-1:0]         idx;
  logic signed [WORD_W-1:0] val;
  logic [CMP_W-1:0]         cnt;
  status_t                  st;
  logic [SWP_W-1:0]         sweep;
  cell_cmd_t                cmd;
  logic                     good;
  logic                     full;

  logic signed [WORD_W-1:0] entry_w [DEPTH];
  logic signed [WORD_W-1:0] next_w  [DEPTH];
  logic signed [WORD_W-1:0] rd_w    [DEPTH];
  logic signed [WORD_W-1:0] rd_in   [DEPTH];
  minmax_t                  mm_w    [DEPTH];
  minmax_t                  mm_in   [DEPTH];

  assign busy = (state != S_IDLE);
  assign good = idx < cnt;
  assign full = (cnt == CMP_W'(DEPTH));

  always_comb begin
    cmd.app   = (state == S_EXEC) && (op == OP_APPEND) && !full;
    cmd.del   = (state == S_EXEC) && (op == OP_DELETE) && good;
    cmd.wr    = (state == S_EXEC) && (op == OP_WRITE) && good;
    cmd.idx   = idx;
    cmd.cnt   = cnt;
    cmd.value = val;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (start) state_next = S_EXEC;
      S_EXEC:  state_next = S_SWEEP;
      S_SWEEP: if (sweep == SWP_W'(DEPTH - 1)) state_next = S_EMIT;
      S_EMIT:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
      sweep <= '0;
    end else begin
      state <= state_next;
      done  <= (state == S_EMIT);
      if (state == S_EXEC) begin
        sweep <= '0;
        if (cmd.app) begin
          cnt <= cnt + CMP_W'(1);
        end else if (cmd.del) begin
          cnt <= cnt - CMP_W'(1);
        end
      end else if (state == S_SWEEP) begin
        sweep <= sweep + SWP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      op  <= op_t'(opcode);
      idx <= CMP_W'(index);
      val <= value;
    end
    if (state == S_EXEC) begin
      if (op == OP_APPEND) begin
        st <= full ? ST_FULL : ST_OK;
      end else begin
        st <= good ? ST_OK : ST_RANGE;
      end
    end
    if (state == S_EMIT) begin
      status <= st;
      count  <= cnt[7:0];
      if (st != ST_OK) begin
        read_word <= '1;
      end else if (op == OP_READ) begin
        read_word <= rd_w[DEPTH-1];
      end else begin
        read_word <= '0;
      end
      max_word <= mm_w[DEPTH-1].any ? mm_w[DEPTH-1].hi : '0;
      min_word <= mm_w[DEPTH-1].any ? mm_w[DEPTH-1].lo : '0;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign mm_in[i] = '0;
      assign rd_in[i] = '0;
    end else begin : g_link
      assign mm_in[i] = mm_w[i-1];
      assign rd_in[i] = rd_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign next_w[i] = '0;
    end else begin : g_next
      assign next_w[i] = entry_w[i+1];
    end

    pate_cell u_cell (
      .clk        (clk),
      .pos        (CMP_W'(i)),
      .cmd        (cmd),
      .next_entry (next_w[i]),
      .entry      (entry_w[i]),
      .prev_mm    (mm_in[i]),
      .mm         (mm_w[i]),
      .prev_rd    (rd_in[i]),
      .rd         (rd_w[i])
    );
  end

endmodule

// File: rtl/pate_checker.sv
// Port-level checker for packed_array_table_engine, bound to the top level.
// Uses pate_pkg for the status codes.

module pate_checker
  import pate_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     start,
  input logic                     busy,
  input logic                     done,
  input logic signed [WORD_W-1:0] read_word,
  input logic [1:0]               status
);

  // An accepted beat keeps the engine busy for the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("engine not busy after accepting a beat");

  // A result strobe never stays high; done falls again straight after it.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  // A result is only shown after the engine has worked on a beat.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a beat in progress");

  // Any error status carries a read word of all ones.
  a_err_word: assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_RANGE || status == ST_FULL) |-> read_word == -32'sd1)
    else $error("error status without all-ones read word");

endmodule

bind packed_array_table_engine pate_checker u_pate_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .read_word (read_word),
  .status    (status)
);
